FILE: rtl/pwm_voltage_loop_overcurrent_restart_core_assert.svh
// Assertion macros shared by the checker
`ifndef PWM_VOLTAGE_LOOP_OVERCURRENT_RESTART_CORE_ASSERT_SVH
`define PWM_VOLTAGE_LOOP_OVERCURRENT_RESTART_CORE_ASSERT_SVH
`define PVL_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define PVL_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: rtl/pvl_pkg.sv
`timescale 1ns / 1ps
package pvl_pkg;
   localparam int PwmPeriodDef   = 2100;
   localparam int RampStepsDef   = 70;
   localparam int RestartDutyDef = 100;

   localparam logic [1:0] CMD_VOLT  = 2'd0;
   localparam logic [1:0] CMD_CURR  = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   localparam logic [2:0] REG_TARGET = 3'd0;
   localparam logic [2:0] REG_LIMIT  = 3'd1;
   localparam logic [2:0] REG_DEADB  = 3'd2;
   localparam logic [2:0] REG_KP     = 3'd3;
   localparam logic [2:0] REG_KI     = 3'd4;
   localparam logic [2:0] REG_KD     = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] sense_mv;
   } req_type;

   typedef struct packed {
      logic [11:0] duty;
      logic        output_enabled;
      logic        regulating;
      logic        in_fault;
      logic        zero_divide;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // latch item, evaluate simple commands
      logic mul_start; // start one serial multiply
      logic [1:0] mul_sel;
      logic acc_add;   // add product to sum
      logic pid_commit;
      logic div_start;
      logic duty_commit;
      logic ramp_start;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_pid;
      logic need_ramp;
      logic mul_done;
      logic div_done;
      logic div_skip;  // numerator not positive, no divide needed
   } sts_type;
endpackage

FILE: rtl/pwm_voltage_loop_overcurrent_restart_core.sv
`timescale 1ns / 1ps
// channel | ports                        | dir
// request | req_valid req_stall req_item | in
// response| rsp_valid rsp_stall rsp_item | out
// config  | csr_write csr_index csr_data | in
// One item at a time. Start, stop, current and idle voltage items pass through
// decode and output; a current item that ramps the duty also takes the ramp state.
// A regulated voltage item: four passes of the serial multiplier plus the
// divider; the divide is skipped when the PID output is not positive.
// Reset is synchronous; no clearing pass. The held result stalls new items.
module pwm_voltage_loop_overcurrent_restart_core
   import pvl_pkg::*;
#(
   parameter int PwmPeriod   = PwmPeriodDef,
   parameter int RampSteps   = RampStepsDef,
   parameter int RestartDuty = RestartDutyDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   pvl_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );
   pvl_dp #(
      .PwmPeriod(PwmPeriod), .RampSteps(RampSteps), .RestartDuty(RestartDuty)
   ) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_item, .cmd, .sts,
      .rsp_item
   );
endmodule

FILE: rtl/pvl_ctrl.sv
`timescale 1ns / 1ps
module pvl_ctrl
   import pvl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_RAMP = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] msel_ff, msel_in;
   logic       busy_ff, busy_in;
   logic       rv_ff, rv_in;

   assign req_stall = (state_ff != S_IDLE) || (rv_ff && rsp_stall);
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      msel_in  = msel_ff;
      busy_in  = busy_ff;
      rv_in    = rv_ff && rsp_stall;
      cmd      = '0;
      cmd.mul_sel = msel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.need_pid) begin
               msel_in = 2'd0;
               busy_in = 1'b0;
               state_in = S_MUL;
            end else if (sts.need_ramp) begin
               cmd.ramp_start = 1'b1;
               state_in = S_RAMP;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            if (!busy_ff) begin
               cmd.mul_start = 1'b1;
               busy_in = 1'b1;
            end else if (sts.mul_done) begin
               busy_in = 1'b0;
               if (msel_ff == 2'd2) begin
                  cmd.acc_add = 1'b1;
                  cmd.pid_commit = 1'b1;
                  state_in = S_DIV;
               end else if (msel_ff == 2'd3) begin
                  if (sts.div_skip) begin
                     cmd.duty_commit = 1'b1;
                     state_in = S_OUT;
                  end else begin
                     cmd.div_start = 1'b1;
                     busy_in = 1'b1;
                     state_in = S_DIV;
                  end
               end else begin
                  cmd.acc_add = 1'b1;
                  msel_in = msel_ff + 2'd1;
               end
            end
         end
         S_DIV: begin
            if (!busy_ff) begin
               msel_in = 2'd3;
               state_in = S_MUL;
            end else if (sts.div_done) begin
               cmd.duty_commit = 1'b1;
               busy_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_RAMP: state_in = S_OUT;
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         msel_ff  <= 2'd0;
         busy_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         msel_ff  <= msel_in;
         busy_ff  <= busy_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

FILE: rtl/pvl_mul.sv
`timescale 1ns / 1ps
// signed 32 x unsigned 18, shift-add
module pvl_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] a,
   input  logic        [17:0] b,
   output logic               done,
   output logic signed [49:0] prod
);
   logic [4:0]         cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic        [17:0] b_ff, b_in;
   logic signed [49:0] a_ff, a_in, p_ff, p_in;

   assign prod = p_ff;
   always_comb begin
      cnt_in = cnt_ff; run_in = run_ff; b_in = b_ff; a_in = a_ff; p_in = p_ff;
      done = 1'b0;
      if (start) begin
         run_in = 1'b1; cnt_in = 5'd0; b_in = b; p_in = '0;
         a_in = 50'(a);
      end else if (run_ff) begin
         if (b_ff[0]) p_in = p_ff + a_ff;
         a_in = a_ff <<< 1;
         b_in = b_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd17) begin
            run_in = 1'b0;
         end
      end
      if (!run_ff && cnt_ff == 5'd18) done = 1'b1;
      if (!run_ff && cnt_ff == 5'd18 && !start) cnt_in = 5'd19;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; cnt_ff <= 5'd19;
      end else begin
         run_ff <= run_in; cnt_ff <= cnt_in;
      end
      b_ff <= b_in; a_ff <= a_in; p_ff <= p_in;
   end
endmodule

FILE: rtl/pvl_div.sv
`timescale 1ns / 1ps
// restoring divide, 45-bit by 28-bit, one bit a cycle
module pvl_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [44:0] num,
   input  logic [27:0] den,
   output logic        done,
   output logic [44:0] quo
);
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [44:0] q_ff, q_in;
   logic [28:0] r_ff, r_in;
   logic [28:0] rs;
   logic [27:0] d_ff, d_in;

   assign quo = q_ff;
   always_comb begin
      cnt_in = cnt_ff; run_in = run_ff; q_in = q_ff; r_in = r_ff; d_in = d_ff;
      rs = {r_ff[27:0], q_ff[44]};
      done = 1'b0;
      if (start) begin
         run_in = 1'b1; cnt_in = 6'd0; q_in = num; r_in = '0; d_in = den;
      end else if (run_ff) begin
         q_in = {q_ff[43:0], 1'b0};
         if (rs >= {1'b0, d_ff}) begin
            r_in = rs - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = rs;
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd44) begin
            run_in = 1'b0;
         end
      end else if (cnt_ff == 6'd45) begin
         done = 1'b1;
         cnt_in = 6'd46;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end
endmodule

FILE: rtl/pvl_dp.sv
`timescale 1ns / 1ps
module pvl_dp
   import pvl_pkg::*;
#(
   parameter int PwmPeriod   = PwmPeriodDef,
   parameter int RampSteps   = RampStepsDef,
   parameter int RestartDuty = RestartDutyDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  req_type     req_item,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     rsp_item
);
   localparam logic [11:0] PERIOD = 12'(PwmPeriod);
   localparam logic [11:0] RDUTY  = 12'(RestartDuty);
   // reciprocals, exact floor over the operand ranges used
   localparam longint unsigned RT_RECIP = ((64'd1 << 29) + 64'd299) / 64'd300;
   localparam logic [40:0] RT_MUL = 41'(64'(PwmPeriod) * RT_RECIP);
   localparam logic [24:0] RS_RECIP =
      25'(((64'd1 << 24) + 64'(RampSteps) - 64'd1) / 64'(RampSteps));

   logic [7:0]  tgt_ff;
   logic [4:0]  lim_ff;
   logic [11:0] db_ff;
   logic [15:0] kp_ff, ki_ff, kd_ff;

   logic [11:0] duty_ff, duty_in;
   logic        pid_on_ff, pid_on_in, fault_ff, fault_in, unl_ff, unl_in;
   logic [11:0] rtgt_ff, rtgt_in, rstep_ff, rstep_in;
   logic        rsu_ff, rsu_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [12:0] e1_ff, e1_in, e2_ff, e2_in;
   logic signed [12:0] e_ff, e_in;
   logic signed [51:0] sum_ff, sum_in;
   logic [1:0]  c_ff, c_in;
   logic [11:0] s_ff, s_in;
   logic        zd_ff, zd_in;
   logic        np_ff, np_in, nr_ff, nr_in;

   logic [12:0] tgt_mv;
   logic signed [14:0] err_raw;
   logic signed [12:0] err_c;
   logic [12:0] mag;
   logic [13:0] lim_mv;

   logic signed [31:0] mul_a;
   logic [17:0]        mul_b;
   logic               mul_done, div_done;
   logic signed [49:0] prod;
   logic [44:0]        quo;
   logic signed [44:0] numr;

   logic [40:0] rt_prod;
   logic [36:0] rs_prod;
   logic [11:0] rt;
   logic [11:0] rs;
   logic [12:0] dsum;

   // target*100/6 = target*50/3, constant reciprocal
   assign tgt_mv  = 13'((30'(tgt_ff) * 30'd50 * 30'd43691) >> 17);
   assign err_raw = 15'(signed'({2'd0, tgt_mv})) - 15'(signed'({3'd0, req_item.sense_mv}));
   assign err_c   = (err_raw > 15'sd4095) ? 13'sd4095 :
                    (err_raw < -15'sd4096) ? -13'sd4096 : 13'(err_raw);
   assign mag     = err_c[12] ? 13'(-err_c) : 13'(err_c);
   assign lim_mv  = 14'(lim_ff) * 14'd150;
   // PWM*t/300
   assign rt_prod = 41'(tgt_ff) * RT_MUL;
   assign rt      = 12'(rt_prod >> 29);
   // step from the latched ramp target, taken in the cycle after the trip
   assign rs_prod = 37'(rtgt_ff - RDUTY) * 37'(RS_RECIP);
   assign rs      = (rtgt_ff > RDUTY) ? 12'(rs_prod >> 24) : 12'd0;

   always_comb begin
      mul_a = acc_ff;
      mul_b = {2'b0, duty_ff} + 18'd1;
      unique case (cmd.mul_sel)
         2'd0: begin
            mul_a = 32'(e_ff);
            mul_b = {2'b0, kp_ff} + {2'b0, ki_ff} + {2'b0, kd_ff};
         end
         2'd1: begin
            mul_a = -32'(e1_ff);
            mul_b = {2'b0, kp_ff} + {1'b0, kd_ff, 1'b0};
         end
         2'd2: begin
            mul_a = 32'(e2_ff);
            mul_b = {2'b0, kd_ff};
         end
         default: begin
            mul_a = acc_ff;
            mul_b = {6'd0, duty_ff} + 18'd1;
         end
      endcase
   end

   pvl_mul u_mul (
      .clock, .reset, .start(cmd.mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(prod)
   );
   assign numr = 45'(prod);
   pvl_div u_div (
      .clock, .reset, .start(cmd.div_start),
      .num(numr), .den({s_ff, 16'd0}), .done(div_done), .quo(quo)
   );

   assign sts.need_pid  = np_ff;
   assign sts.need_ramp = nr_ff;
   assign sts.mul_done  = mul_done;
   assign sts.div_done  = div_done;
   assign sts.div_skip  = numr[44] || numr == '0;

   always_comb begin
      duty_in = duty_ff; pid_on_in = pid_on_ff; fault_in = fault_ff; unl_in = unl_ff;
      rtgt_in = rtgt_ff; rstep_in = rstep_ff; acc_in = acc_ff; e1_in = e1_ff;
      e2_in = e2_ff; e_in = e_ff; sum_in = sum_ff; c_in = c_ff; s_in = s_ff;
      zd_in = zd_ff; np_in = 1'b0; nr_in = 1'b0; rsu_in = 1'b0;
      dsum = 13'(duty_ff) + 13'(rstep_ff);
      if (rsu_ff) rstep_in = (rs == 12'd0) ? 12'd1 : rs;
      if (cmd.load) begin
         c_in = req_item.cmd; s_in = req_item.sense_mv; e_in = err_c;
         zd_in = 1'b0; sum_in = 52'(acc_ff);
         unique case (req_item.cmd)
            CMD_VOLT: begin
               if (pid_on_ff && (mag > {1'b0, db_ff})) begin
                  if (req_item.sense_mv == 12'd0) zd_in = 1'b1;
                  else np_in = 1'b1;
               end
            end
            CMD_CURR: begin
               if ({2'b0, req_item.sense_mv} > lim_mv && !fault_ff) begin
                  unl_in = 1'b0; pid_on_in = 1'b0; fault_in = 1'b1;
                  rtgt_in = rt; duty_in = RDUTY;
                  rsu_in = 1'b1;
               end else if (fault_ff && {2'b0, req_item.sense_mv} <= lim_mv) begin
                  nr_in = 1'b1;
               end
            end
            CMD_START: pid_on_in = 1'b1;
            CMD_STOP: begin
               pid_on_in = 1'b0; duty_in = RDUTY;
            end
            default: ;
         endcase
      end
      if (cmd.ramp_start) begin
         unl_in = 1'b1;
         if (duty_ff <= rtgt_ff) begin
            duty_in = (dsum > 13'(PERIOD)) ? PERIOD : 12'(dsum);
         end else begin
            fault_in = 1'b0; pid_on_in = 1'b1;
         end
      end
      if (cmd.acc_add) sum_in = sum_ff + 52'(prod);
      if (cmd.pid_commit) begin
         if (sum_in > 52'sh7FFFFFFF) acc_in = 32'sh7FFFFFFF;
         else if (sum_in < -52'sh80000000) acc_in = -32'sh80000000;
         else acc_in = 32'(sum_in);
         e2_in = e1_ff; e1_in = e_ff;
      end
      if (cmd.duty_commit) begin
         if (numr[44] || numr == '0) duty_in = 12'd0;
         else if (quo > 45'(PERIOD)) duty_in = PERIOD;
         else duty_in = 12'(quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= 8'd30; lim_ff <= 5'd20; db_ff <= 12'd10;
         kp_ff <= 16'd7864; ki_ff <= 16'd4588; kd_ff <= 16'd3932;
         duty_ff <= RDUTY; pid_on_ff <= 1'b0; fault_ff <= 1'b0; unl_ff <= 1'b1;
         rtgt_ff <= '0; rstep_ff <= '0; acc_ff <= '0; e1_ff <= '0; e2_ff <= '0;
         np_ff <= 1'b0; nr_ff <= 1'b0; zd_ff <= 1'b0; rsu_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_TARGET: tgt_ff <= csr_data[7:0];
               REG_LIMIT:  lim_ff <= csr_data[4:0];
               REG_DEADB:  db_ff  <= csr_data[11:0];
               REG_KP:     kp_ff  <= csr_data;
               REG_KI:     ki_ff  <= csr_data;
               REG_KD:     kd_ff  <= csr_data;
               default: ;
            endcase
         end
         duty_ff <= duty_in; pid_on_ff <= pid_on_in; fault_ff <= fault_in;
         unl_ff <= unl_in; rtgt_ff <= rtgt_in; rstep_ff <= rstep_in;
         acc_ff <= acc_in; e1_ff <= e1_in; e2_ff <= e2_in;
         np_ff <= np_in; nr_ff <= nr_in; zd_ff <= zd_in; rsu_ff <= rsu_in;
      end
      e_ff <= e_in; sum_ff <= sum_in; c_ff <= c_in; s_ff <= s_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_item <= '0;
      end else if (cmd.load || cmd.ramp_start || cmd.duty_commit || np_ff || nr_ff ||
                   c_ff == CMD_VOLT || c_ff != CMD_VOLT) begin
         rsp_item.duty           <= duty_in;
         rsp_item.output_enabled <= unl_in;
         rsp_item.regulating     <= pid_on_in;
         rsp_item.in_fault       <= fault_in;
         rsp_item.zero_divide    <= zd_in;
      end
   end
endmodule

FILE: rtl/pvl_checker.sv
`timescale 1ns / 1ps
`include "pwm_voltage_loop_overcurrent_restart_core_assert.svh"
module pvl_checker
   import pvl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);
   `PVL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
   `PVL_ASSERT_IMP(a_busy, clock, reset, rsp_valid && rsp_stall, req_stall)
   `PVL_ASSERT_IMP(a_fault_lock, clock, reset, rsp_valid && !rsp_item.output_enabled, rsp_item.in_fault)
   `PVL_ASSERT_IMP(a_zdiv_reg, clock, reset, rsp_valid && rsp_item.zero_divide, rsp_item.regulating)
endmodule

bind pwm_voltage_loop_overcurrent_restart_core pvl_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_item
);
